/* src/plc_pkg.sv */
// -----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the piecewise linear calibration block.
// -----------------------------------------------------------------------------
package plc_pkg;

    localparam int NUM_POINTS_DEF = 21;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int SAMPLE_W   = 32;
    localparam int INDEX_W    = 5;
    localparam int VALUE_W    = 48;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int ACC_W      = 2 * DIFF_W + 1;
    localparam int MAG_W      = 2 * DIFF_W;
    localparam int DEN_W      = 39;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 88;
    localparam int STATUS_W   = 2;

    typedef enum logic [1:0] {
        ST_LOADED   = 2'd0,
        ST_MEASURED = 2'd1,
        ST_UNCAL    = 2'd2,
        ST_BAD_IDX  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_STEP,
        RD_SEG,
        RD_SEG1
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_WCHK,
        S_FA,
        S_FB,
        S_PREP,
        S_MULA,
        S_MULB,
        S_DIVI,
        S_DIV,
        S_RND,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    load_wr;
        rd_sel_t rd_sel;
        logic    walk;
        logic    walk_first;
        logic    fetch_a;
        logic    fetch_b;
        logic    prep;
        logic    mul_a;
        logic    mul_b;
        logic    div_init;
        logic    div_step;
        logic    round;
        logic    res_load;
        status_t res_code;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic bad_index;
        logic loaded_all;
        logic cal_bad;
        logic out_busy;
    } stat_t;

endpackage

/* src/plc_ctrl.sv */
// -----------------------------------------------------------------------------
// plc_ctrl
// Sequencer: decodes an item, walks the table, drives the multiply and the
// serial divide, and hands the result to the output register.
// -----------------------------------------------------------------------------
module plc_ctrl #(
    parameter int NUM_POINTS = plc_pkg::NUM_POINTS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  plc_pkg::stat_t stat,
    output plc_pkg::cmd_t  cmd,
    output logic [$clog2(((plc_pkg::MAG_W + FRAC_BITS) > NUM_POINTS ?
                   (plc_pkg::MAG_W + FRAC_BITS) : NUM_POINTS) + 1) - 1:0] step
);

    localparam int NW    = plc_pkg::MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2((NW > NUM_POINTS ? NW : NUM_POINTS) + 1);

    plc_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    plc_pkg::status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plc_pkg::S_IDLE;
            cnt_reg   <= '0;
            code_reg  <= plc_pkg::ST_LOADED;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
        end
    end

    assign step = cnt_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        code_next    = code_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = plc_pkg::RD_NONE;
        cmd.res_code = code_reg;
        case (state_reg)
            plc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = plc_pkg::S_DECIDE;
                end
            end
            plc_pkg::S_DECIDE:
            begin
                state_next = plc_pkg::S_OUT;
                if (!stat.op)
                begin
                    if (stat.bad_index)
                        code_next = plc_pkg::ST_BAD_IDX;
                    else
                    begin
                        cmd.load_wr = 1'b1;
                        code_next   = plc_pkg::ST_LOADED;
                    end
                end
                else if (!stat.loaded_all)
                    code_next = plc_pkg::ST_UNCAL;
                else
                begin
                    cnt_next   = '0;
                    state_next = plc_pkg::S_WALK;
                end
            end
            plc_pkg::S_WALK:
            begin
                if (cnt_reg < CNT_W'(NUM_POINTS))
                    cmd.rd_sel = plc_pkg::RD_STEP;
                if (cnt_reg != '0)
                begin
                    cmd.walk       = 1'b1;
                    cmd.walk_first = (cnt_reg == CNT_W'(1));
                end
                if (cnt_reg == CNT_W'(NUM_POINTS))
                    state_next = plc_pkg::S_WCHK;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            plc_pkg::S_WCHK:
            begin
                cmd.rd_sel = plc_pkg::RD_SEG;
                if (stat.cal_bad)
                begin
                    code_next  = plc_pkg::ST_UNCAL;
                    state_next = plc_pkg::S_OUT;
                end
                else
                    state_next = plc_pkg::S_FA;
            end
            plc_pkg::S_FA:
            begin
                cmd.fetch_a = 1'b1;
                cmd.rd_sel  = plc_pkg::RD_SEG1;
                state_next  = plc_pkg::S_FB;
            end
            plc_pkg::S_FB:
            begin
                cmd.fetch_b = 1'b1;
                state_next  = plc_pkg::S_PREP;
            end
            plc_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = plc_pkg::S_MULA;
            end
            plc_pkg::S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = plc_pkg::S_MULB;
            end
            plc_pkg::S_MULB:
            begin
                cmd.mul_b  = 1'b1;
                state_next = plc_pkg::S_DIVI;
            end
            plc_pkg::S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = plc_pkg::S_DIV;
            end
            plc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                    state_next = plc_pkg::S_RND;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            plc_pkg::S_RND:
            begin
                cmd.round  = 1'b1;
                code_next  = plc_pkg::ST_MEASURED;
                state_next = plc_pkg::S_OUT;
            end
            plc_pkg::S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = plc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* src/plc_dp.sv */
// -----------------------------------------------------------------------------
// plc_dp
// Datapath: calibration table, segment walk, shared multiplier, restoring
// divider, rounding, saturation and the output register.
// -----------------------------------------------------------------------------
module plc_dp #(
    parameter int NUM_POINTS = plc_pkg::NUM_POINTS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plc_pkg::cmd_t                       cmd,
    input  logic [$clog2(((plc_pkg::MAG_W + FRAC_BITS) > NUM_POINTS ?
                   (plc_pkg::MAG_W + FRAC_BITS) : NUM_POINTS) + 1) - 1:0] step,
    output plc_pkg::stat_t                      stat,
    input  logic                                scale,
    input  logic                                in_op,
    input  logic [plc_pkg::IN_DATA_W-1:0]       in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [plc_pkg::STATUS_W-1:0]        out_status,
    output logic [plc_pkg::OUT_DATA_W-1:0]      out_data
);

    localparam int AW    = $clog2(NUM_POINTS);
    localparam int NW    = plc_pkg::MAG_W + FRAC_BITS;
    localparam int SW    = plc_pkg::SAMPLE_W;
    localparam int DW    = plc_pkg::DIFF_W;
    localparam int ACCW  = plc_pkg::ACC_W;
    localparam int DENW  = plc_pkg::DEN_W;
    localparam int VW    = plc_pkg::VALUE_W;
    localparam int CNT_W = $clog2((NW > NUM_POINTS ? NW : NUM_POINTS) + 1);

    logic                         op_reg;
    logic [plc_pkg::INDEX_W-1:0]  idx_reg;
    logic signed [SW-1:0]         pv_reg, mv_reg, x_reg;

    logic signed [SW-1:0]         pts_mem [NUM_POINTS];
    logic signed [SW-1:0]         rdg_mem [NUM_POINTS];
    logic [NUM_POINTS-1:0]        loaded_reg;
    logic signed [SW-1:0]         pt_rd_reg, rg_rd_reg;
    logic [AW-1:0]                rd_addr;
    logic                         rd_en;

    logic signed [SW-1:0]         prev_reg;
    logic [AW-1:0]                seg_reg;
    logic                         found_reg, eq_reg;

    logic signed [SW-1:0]         p1_reg, m1_reg, p2_reg, m2_reg;
    logic signed [DW-1:0]         d_reg, dx_reg, dp_reg;
    logic [SW-1:0]                dmag_reg;
    logic [DENW-1:0]              den_reg;
    logic signed [ACCW-1:0]       acc_reg;
    logic [NW-1:0]                num_reg;
    logic [DENW-1:0]              rem_reg;
    logic                         neg_reg;
    logic [NW:0]                  q_reg;

    logic                         ovalid_reg;
    logic [plc_pkg::STATUS_W-1:0] ostat_reg;
    logic [plc_pkg::OUT_DATA_W-1:0] odata_reg;

    logic [AW-1:0]                pair_idx;
    logic                         lt, i0, match;
    logic signed [DW-1:0]         mul_x, mul_y;
    logic signed [2*DW-1:0]       prod;
    logic signed [ACCW-1:0]       prod_ext;
    logic [ACCW-1:0]              acc_abs;
    logic [DENW:0]                trial;
    logic                         qbit;
    logic [NW:0]                  lim;
    logic                         sat;
    logic [VW-1:0]                mag, val;
    logic [plc_pkg::OUT_DATA_W-1:0] res_data;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = seg_reg;
        case (cmd.rd_sel)
            plc_pkg::RD_STEP: rd_addr = step[AW-1:0];
            plc_pkg::RD_SEG:  rd_addr = seg_reg;
            plc_pkg::RD_SEG1: rd_addr = seg_reg + 1'b1;
            default:          rd_en   = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            pts_mem[idx_reg[AW-1:0]] <= pv_reg;
            rdg_mem[idx_reg[AW-1:0]] <= mv_reg;
        end
        if (rd_en)
        begin
            pt_rd_reg <= pts_mem[rd_addr];
            rg_rd_reg <= rdg_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loaded_reg <= '0;
        else if (cmd.load_wr)
            loaded_reg[idx_reg[AW-1:0]] <= 1'b1;
    end

    assign pair_idx = AW'(step - CNT_W'(2));
    assign i0       = (pair_idx == '0);
    assign lt       = prev_reg < rg_rd_reg;
    assign match    = lt ? ((i0 && x_reg <= rg_rd_reg) ||
                            (x_reg >= prev_reg && x_reg <= rg_rd_reg))
                         : ((i0 && x_reg >= rg_rd_reg) ||
                            (x_reg <= prev_reg && x_reg >= rg_rd_reg));

    assign mul_x    = cmd.mul_b ? dp_reg : DW'(p1_reg);
    assign mul_y    = cmd.mul_b ? dx_reg : d_reg;
    assign prod     = mul_x * mul_y;
    assign prod_ext = ACCW'(prod);
    assign acc_abs  = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);

    assign trial = {rem_reg, num_reg[NW-1]};
    assign qbit  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            idx_reg <= in_data[4:0];
            pv_reg  <= in_data[36:5];
            mv_reg  <= in_data[68:37];
            x_reg   <= in_data[100:69];
        end
        if (cmd.capture)
        begin
            seg_reg   <= AW'(NUM_POINTS - 2);
            found_reg <= 1'b0;
            eq_reg    <= 1'b0;
        end
        if (cmd.walk)
        begin
            prev_reg <= rg_rd_reg;
            if (!cmd.walk_first)
            begin
                if (prev_reg == rg_rd_reg)
                    eq_reg <= 1'b1;
                if (match && !found_reg)
                begin
                    seg_reg   <= pair_idx;
                    found_reg <= 1'b1;
                end
            end
        end
        if (cmd.fetch_a)
        begin
            p1_reg <= pt_rd_reg;
            m1_reg <= rg_rd_reg;
        end
        if (cmd.fetch_b)
        begin
            p2_reg <= pt_rd_reg;
            m2_reg <= rg_rd_reg;
        end
        if (cmd.prep)
        begin
            d_reg  <= DW'(m2_reg) - DW'(m1_reg);
            dx_reg <= DW'(x_reg) - DW'(m1_reg);
            dp_reg <= DW'(p2_reg) - DW'(p1_reg);
        end
        if (cmd.mul_a)
        begin
            acc_reg  <= prod_ext;
            dmag_reg <= d_reg[DW-1] ? SW'(-d_reg) : SW'(d_reg);
        end
        if (cmd.mul_b)
        begin
            acc_reg <= acc_reg + prod_ext;
            den_reg <= scale ? (DENW'(dmag_reg) << 6) + (DENW'(dmag_reg) << 5)
                               + (DENW'(dmag_reg) << 2)
                             : DENW'(dmag_reg);
        end
        if (cmd.div_init)
        begin
            num_reg <= NW'(acc_abs[plc_pkg::MAG_W-1:0]) << FRAC_BITS;
            rem_reg <= '0;
            neg_reg <= acc_reg[ACCW-1] ^ d_reg[DW-1];
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? DENW'(trial - {1'b0, den_reg}) : DENW'(trial);
            num_reg <= {num_reg[NW-2:0], qbit};
        end
        if (cmd.round)
            q_reg <= {1'b0, num_reg} +
                     (NW+1)'({rem_reg, 1'b0} >= {1'b0, den_reg});
    end

    assign lim = neg_reg ? (NW+1)'(64'd1 << (VW - 1))
                         : (NW+1)'((64'd1 << (VW - 1)) - 64'd1);
    assign sat = q_reg > lim;
    assign mag = sat ? lim[VW-1:0] : q_reg[VW-1:0];
    assign val = neg_reg ? VW'(-mag) : mag;

    always_comb
    begin
        res_data = '0;
        case (cmd.res_code)
            plc_pkg::ST_MEASURED:
                res_data = {2'b00, sat, x_reg, 5'(seg_reg), val};
            plc_pkg::ST_UNCAL:
                res_data = {2'b00, 1'b0, x_reg, 5'd0, {VW{1'b0}}};
            default:
                res_data = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.res_load)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            ostat_reg <= cmd.res_code;
            odata_reg <= res_data;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_data   = odata_reg;

    assign stat.op         = op_reg;
    assign stat.bad_index  = {1'b0, idx_reg} >= 6'(NUM_POINTS);
    assign stat.loaded_all = &loaded_reg;
    assign stat.cal_bad    = eq_reg;
    assign stat.out_busy   = ovalid_reg && !out_ready;

endmodule

/* src/piecewise_linear_calibration.sv */
// -----------------------------------------------------------------------------
// piecewise_linear_calibration
// Converts raw meter readings to calibrated values by piecewise linear
// interpolation over a loaded table of calibration points.
// -----------------------------------------------------------------------------
// One item at a time. A load passes through S_DECIDE and S_OUT before its result
// is valid. A measure on a loaded table walks the table with one table read per
// cycle, then runs a restoring divider that retires one quotient bit per cycle
// over the 66 + FRAC_BITS bit numerator. The next word is accepted in the cycle
// after the result is loaded. A new word is taken while a finished result still
// waits at the output.
module piecewise_linear_calibration #(
    parameter int NUM_POINTS = plc_pkg::NUM_POINTS_DEF,
    parameter int FRAC_BITS  = plc_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_index, point_value, meas_value, raw_sample
    input  logic [plc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // value, segment, raw_echo, saturated
    output logic [plc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [plc_pkg::STATUS_W-1:0]    m_axis_tuser
);

    localparam int NW    = plc_pkg::MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2((NW > NUM_POINTS ? NW : NUM_POINTS) + 1);

    logic           scale_reg;
    plc_pkg::cmd_t  cmd;
    plc_pkg::stat_t stat;
    logic [CNT_W-1:0] step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 3'd0)
            scale_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {31'd0, scale_reg} : 32'd0;

    plc_ctrl #(
        .NUM_POINTS (NUM_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .step     (step)
    );

    plc_dp #(
        .NUM_POINTS (NUM_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .step       (step),
        .stat       (stat),
        .scale      (scale_reg),
        .in_op      (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

endmodule

/* sim/tb_piecewise_linear_calibration.sv */
// -----------------------------------------------------------------------------
// tb_piecewise_linear_calibration
// Self-checking bench for the piecewise linear calibration block. Loads
// calibration tables (rising, falling, zigzag, broken), converts raw
// readings against an internal interpolation predictor, toggles the
// hundredths scaling over APB, and checks every output word in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_piecewise_linear_calibration;

    localparam int NPTS      = 21;
    localparam int FRAC      = 16;
    localparam int N_ITEMS   = 1800;
    localparam int MAX_CYC   = 2000000;
    localparam int MAX_ERR   = 10;
    localparam int HOLD_CYC  = 400;
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_MEASURE = 1'b1;
    localparam logic [2:0] ADDR_SCALE = 3'd0;

    typedef struct {
        plc_pkg::status_t   status;
        logic signed [47:0] value;
        logic [4:0]         segment;
        logic signed [31:0] raw_echo;
        logic               saturated;
    } cal_word_t;

    typedef struct {
        logic               op;
        logic [4:0]         idx;
        logic signed [31:0] pv;
        logic signed [31:0] mv;
        logic signed [31:0] raw;
        logic               typed;
        cal_word_t          want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [plc_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [plc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [plc_pkg::STATUS_W-1:0]   m_axis_tuser;

    // calibration table copy
    logic signed [31:0] tab_point [NPTS];
    logic signed [31:0] tab_read  [NPTS];
    logic               tab_valid [NPTS];
    logic               scale_on;

    cal_word_t expected_words[$];
    stim_row_t dir_rows[$];

    int  n_err;
    int  n_sent;
    int  n_measured, n_saturated, n_uncal, n_badidx;
    int  cyc;
    bit  idle_on;
    int  hold_req;
    int  hold_done;
    int  stall_left;

    piecewise_linear_calibration u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cal_word_t plain_word(plc_pkg::status_t st,
                                             logic signed [31:0] echo);
        cal_word_t w;
        w.status    = st;
        w.value     = '0;
        w.segment   = '0;
        w.raw_echo  = echo;
        w.saturated = 1'b0;
        return w;
    endfunction

    function automatic cal_word_t interpolate(logic signed [31:0] x);
        cal_word_t w;
        int seg;
        logic signed [127:0] p1, p2, m1, m2, d, xs, n;
        logic [127:0] mag, den, q, r, lim;
        logic neg, sat;
        for (int i = 0; i < NPTS; i++)
            if (!tab_valid[i])
                return plain_word(plc_pkg::ST_UNCAL, x);
        for (int i = 0; i + 1 < NPTS; i++)
            if (tab_read[i] == tab_read[i+1])
                return plain_word(plc_pkg::ST_UNCAL, x);
        seg = NPTS - 2;
        for (int i = 0; i + 1 < NPTS; i++)
        begin
            if (tab_read[i] < tab_read[i+1])
            begin
                if ((i == 0 && x <= tab_read[i+1]) ||
                    (x >= tab_read[i] && x <= tab_read[i+1]))
                begin
                    seg = i;
                    break;
                end
            end
            else if ((i == 0 && x >= tab_read[i+1]) ||
                     (x <= tab_read[i] && x >= tab_read[i+1]))
            begin
                seg = i;
                break;
            end
        end
        p1 = tab_point[seg];
        p2 = tab_point[seg+1];
        m1 = tab_read[seg];
        m2 = tab_read[seg+1];
        xs = x;
        d  = m2 - m1;
        n  = (p1 * d + (p2 - p1) * (xs - m1)) <<< FRAC;
        neg = n < 0;
        mag = neg ? -n : n;
        den = (d < 0 ? -d : d) * (scale_on ? 100 : 1);
        if (d < 0)
            neg = ~neg;
        q = mag / den;
        r = mag % den;
        if (r >= den - r)
            q = q + 1;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
        sat = q > lim;
        if (sat)
            q = lim;
        w.status    = plc_pkg::ST_MEASURED;
        w.value     = neg ? -q[47:0] : q[47:0];
        w.segment   = seg[4:0];
        w.raw_echo  = x;
        w.saturated = sat;
        return w;
    endfunction

    function automatic cal_word_t apply_word(logic op, logic [4:0] idx,
                                             logic signed [31:0] pv,
                                             logic signed [31:0] mv,
                                             logic signed [31:0] raw);
        if (op == OP_MEASURE)
            return interpolate(raw);
        if (idx >= NPTS)
            return plain_word(plc_pkg::ST_BAD_IDX, '0);
        tab_point[idx] = pv;
        tab_read[idx]  = mv;
        tab_valid[idx] = 1'b1;
        return plain_word(plc_pkg::ST_LOADED, '0);
    endfunction

    task automatic send_word(logic op, logic [4:0] idx, logic signed [31:0] pv,
                             logic signed [31:0] mv, logic signed [31:0] raw,
                             bit typed = 0,
                             cal_word_t want = '{status: plc_pkg::ST_LOADED,
                                                 default: '0});
        cal_word_t w;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, raw, mv, pv, idx};
        do @(posedge clk); while (!s_axis_tready);
        w = apply_word(op, idx, pv, mv, raw);
        if (typed)
            w = want;
        if (w.status == plc_pkg::ST_MEASURED)
        begin
            n_measured++;
            if (w.saturated)
                n_saturated++;
        end
        if (w.status == plc_pkg::ST_UNCAL)
            n_uncal++;
        if (w.status == plc_pkg::ST_BAD_IDX)
            n_badidx++;
        expected_words = {expected_words, w};
        n_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_scale(logic v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SCALE;
        pwdata  <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        scale_on = v;
    endtask

    // kind: 0 rising narrow, 1 rising wide, 2 falling, 3 zigzag, 4 one flat pair
    task automatic load_table(int kind);
        longint rd;
        logic signed [31:0] pv;
        logic signed [31:0] reads [NPTS];
        int j;
        rd = (kind == 1) ? -64'sd2147483648 + $urandom_range(0, 100)
                         : longint'($urandom_range(0, 2000000)) - 1000000;
        for (int i = 0; i < NPTS; i++)
        begin
            reads[i] = rd[31:0];
            if (kind == 1)
                rd = rd + $urandom_range(1, 190000000);
            else if (kind == 2)
                rd = rd - $urandom_range(1, 1000);
            else if (kind == 3)
                rd = rd + ((i % 2) ? -1 : 1) * longint'($urandom_range(1, 5000));
            else
                rd = rd + $urandom_range(1, 1000);
        end
        if (kind == 4)
        begin
            j = $urandom_range(1, NPTS-1);
            reads[j] = reads[j-1];
        end
        for (int i = 0; i < NPTS; i++)
        begin
            pv = ($urandom_range(0, 3) == 0) ? $urandom()
                                             : $signed($urandom_range(0, 200000)) - 100000;
            send_word(OP_LOAD, i[4:0], pv, reads[i], $urandom());
        end
    endtask

    function automatic logic signed [31:0] pick_raw();
        int i;
        i = $urandom_range(0, NPTS-1);
        case ($urandom_range(0, 5))
            0: return tab_read[i];
            1: return tab_read[i] + $signed($urandom_range(0, 40)) - 20;
            2: return $urandom();
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default:
                return tab_read[i] +
                       (tab_read[i == NPTS-1 ? i : i+1] - tab_read[i]) / 2;
        endcase
    endfunction

    function automatic stim_row_t mk_row(logic op, logic [4:0] idx,
                                         logic signed [31:0] pv, logic signed [31:0] mv,
                                         logic signed [31:0] raw, bit typed,
                                         plc_pkg::status_t st, logic signed [31:0] echo);
        stim_row_t r;
        r.op = op; r.idx = idx; r.pv = pv; r.mv = mv; r.raw = raw;
        r.typed = typed;
        r.want = plain_word(st, echo);
        return r;
    endfunction

    // output side: check, then choose next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                cal_word_t got, w;
                got.status    = plc_pkg::status_t'(m_axis_tuser);
                got.value     = m_axis_tdata[47:0];
                got.segment   = m_axis_tdata[52:48];
                got.raw_echo  = m_axis_tdata[84:53];
                got.saturated = m_axis_tdata[85];
                if (expected_words.size() == 0)
                begin
                    n_err++;
                    if (n_err <= MAX_ERR)
                        $display("ERROR: unexpected word st=%0d val=%0d", got.status, got.value);
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (got.status !== w.status || got.value !== w.value ||
                        got.segment !== w.segment || got.raw_echo !== w.raw_echo ||
                        got.saturated !== w.saturated)
                    begin
                        n_err++;
                        if (n_err <= MAX_ERR)
                        begin
                            $display("ERROR: exp st=%0d val=%0d seg=%0d echo=%0d sat=%0d",
                                     w.status, w.value, w.segment, w.raw_echo,
                                     w.saturated);
                            $display("       got st=%0d val=%0d seg=%0d echo=%0d sat=%0d",
                                     got.status, got.value, got.segment, got.raw_echo,
                                     got.saturated);
                        end
                    end
                end
            end
            if (hold_req != hold_done)
            begin
                hold_done  = hold_req;
                stall_left = HOLD_CYC;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc >= MAX_CYC)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        int kind;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        n_err = 0; n_sent = 0; cyc = 0; stall_left = 0; hold_req = 0; hold_done = 0;
        n_measured = 0; n_saturated = 0; n_uncal = 0; n_badidx = 0;
        idle_on = 1; scale_on = 1'b0;
        for (int i = 0; i < NPTS; i++)
        begin
            tab_point[i] = '0;
            tab_read[i]  = '0;
            tab_valid[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: uncalibrated, bad slots, zigzag extreme table, edges
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, 32'sh7fffffff, 1'b1,
                                     plc_pkg::ST_UNCAL, 32'sh7fffffff)};
        dir_rows = {dir_rows, mk_row(OP_LOAD, 5'd21, 32'sh7fffffff, 1, 0, 1'b1,
                                     plc_pkg::ST_BAD_IDX, 0)};
        dir_rows = {dir_rows, mk_row(OP_LOAD, 5'd31, 32'sh80000000, 2, 0, 1'b1,
                                     plc_pkg::ST_BAD_IDX, 0)};
        for (int i = 0; i < NPTS; i++)
            dir_rows = {dir_rows, mk_row(OP_LOAD, i[4:0],
                                         (i % 2) ? 32'sh80000000 : 32'sh7fffffff,
                                         -100 + 10 * i, 0, 1'b1, plc_pkg::ST_LOADED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, 32'sh80000000, 1'b0,
                                     plc_pkg::ST_MEASURED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, 32'sh7fffffff, 1'b0,
                                     plc_pkg::ST_MEASURED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, -100, 1'b0,
                                     plc_pkg::ST_MEASURED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, 100, 1'b0,
                                     plc_pkg::ST_MEASURED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, -35, 1'b0,
                                     plc_pkg::ST_MEASURED, 0)};
        dir_rows = {dir_rows, mk_row(OP_LOAD, 5'd1, 0, -100, 0, 1'b1,
                                     plc_pkg::ST_LOADED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, 7, 1'b1,
                                     plc_pkg::ST_UNCAL, 7)};
        dir_rows = {dir_rows, mk_row(OP_LOAD, 5'd1, 0, -90, 0, 1'b1,
                                     plc_pkg::ST_LOADED, 0)};
        dir_rows = {dir_rows, mk_row(OP_MEASURE, 5'd0, 0, 0, -95, 1'b0,
                                     plc_pkg::ST_MEASURED, 0)};
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            send_word(r.op, r.idx, r.pv, r.mv, r.raw, r.typed, r.want);
        end
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_scale(1'(ph % 2));
            if (ph == 3)
                idle_on = 0;
            while (n_sent < (ph + 1) * N_ITEMS / 4)
            begin
                kind = $urandom_range(0, 9);
                load_table(kind > 4 ? $urandom_range(0, 1) : kind);
                for (int k = 0; k < 60; k++)
                begin
                    if (ph == 1 && k == 10 && kind == 0)
                        hold_req++;
                    case ($urandom_range(0, 19))
                        0: send_word(OP_LOAD, 5'($urandom_range(21, 31)), $urandom(),
                                     $urandom(), $urandom());
                        1: send_word(OP_LOAD, 5'($urandom_range(0, NPTS-1)), $urandom(),
                                     tab_read[$urandom_range(0, NPTS-1)] + 1, $urandom());
                        default: send_word(OP_MEASURE, 5'($urandom()), $urandom(),
                                           $urandom(), pick_raw());
                    endcase
                end
            end
            drain();
        end
        hold_req++;
        load_table(0);
        for (int k = 0; k < 30; k++)
            send_word(OP_MEASURE, 5'd0, 0, 0, pick_raw());
        drain();
        repeat (120) @(posedge clk);

        $display("Run covered %0d words: %0d converted (%0d clipped), %0d uncalibrated,",
                 n_sent, n_measured, n_saturated, n_uncal);
        $display("%0d rejected slots, with scaling off and on.", n_badidx);
        if (n_err == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
src/plc_pkg.sv
src/plc_ctrl.sv
src/plc_dp.sv
src/piecewise_linear_calibration.sv
sim/tb_piecewise_linear_calibration.sv
